[rtl/iba_pkg.sv]
// ----------------------------------------------------------------------------
// iba_pkg
// Shared types and codes of the indexed block allocator.
// ----------------------------------------------------------------------------
package iba_pkg;

  localparam int ACTION_W = 2;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = 7;
  localparam int BLK_W    = 7;
  localparam int STATUS_W = 3;
  localparam int FREE_W   = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT    = 2'd0,
    ACT_DELETE    = 2'd1,
    ACT_TRANSLATE = 2'd2,
    ACT_NONE      = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_TOO_BIG   = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_NO_SLOT   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_BAD_INDEX = 3'd5
  } status_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    file_key;
    logic [CNT_W-1:0]    block_count;
    logic [CNT_W-1:0]    logical_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    index_blk;
    logic [BLK_W-1:0]    physical_block;
    logic [CNT_W-1:0]    file_blocks;
    logic [FREE_W-1:0]   free_blocks;
  } rsp_t;

endpackage

[rtl/iba_if.sv]
// ----------------------------------------------------------------------------
// iba_req_if / iba_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface iba_req_if;
  logic          valid;
  logic          ready;
  iba_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface iba_rsp_if;
  logic          valid;
  logic          ready;
  iba_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/iba_queue.sv]
// ----------------------------------------------------------------------------
// iba_queue
// Two-entry request queue between front and back end.
// ----------------------------------------------------------------------------
module iba_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  iba_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output iba_pkg::req_t out_data
);
  iba_pkg::req_t mem [2];
  logic       wptr, rptr;
  logic [1:0] fill;
  logic       push, pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_data  = mem[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= in_data;
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

[rtl/iba_front.sv]
// ----------------------------------------------------------------------------
// iba_front
// Accepts requests and normalizes them: masks the key to KEY_BITS bits.
// ----------------------------------------------------------------------------
module iba_front #(
  parameter int KEY_BITS = 32
) (
  input  logic          in_valid,
  output logic          in_ready,
  input  iba_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output iba_pkg::req_t out_data
);
  localparam int KB = (KEY_BITS < iba_pkg::KEY_W) ? KEY_BITS : iba_pkg::KEY_W;
  logic [iba_pkg::KEY_W-1:0] kmask;

  always_comb begin
    kmask = '0;
    kmask[KB-1:0] = '1;
    out_data = in_data;
    out_data.file_key = in_data.file_key & kmask;
  end

  assign out_valid = in_valid;
  assign in_ready  = out_ready;
endmodule

[rtl/iba_back.sv]
// ----------------------------------------------------------------------------
// iba_back
// Executes one request at a time: slot search, bitmap scan, pointer table.
// ----------------------------------------------------------------------------
module iba_back #(
  parameter int NUM_BLOCKS = 128,
  parameter int NUM_FILES  = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  iba_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output iba_pkg::rsp_t out_data
);
  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int SW = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
  localparam int FW = $clog2(NUM_BLOCKS + 1);
  localparam int PW = SW + BW;

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_SCAN, S_DEL_RD, S_DEL_FREE, S_TR_RD, S_TR_WAIT, S_OUT
  } state_t;

  state_t state;
  state_t dec_state;
  iba_pkg::req_t req;

  logic [NUM_BLOCKS-1:0] block_used;
  logic [NUM_FILES-1:0]  slot_valid;
  logic [iba_pkg::KEY_W-1:0] slot_key   [NUM_FILES];
  logic [BW-1:0]             slot_ib    [NUM_FILES];
  logic [iba_pkg::CNT_W-1:0] slot_cnt   [NUM_FILES];
  logic [BW-1:0]             ptr_mem    [NUM_FILES*(2**BW)];
  logic [BW-1:0]             ptr_rd;
  logic                      ptr_we, ptr_re;
  logic [PW-1:0]             ptr_wa, ptr_ra;
  logic [BW-1:0]             ptr_wd;

  logic [FW-1:0] free_count;
  logic [SW:0]   sidx;          // search counter, one wider to reach NUM_FILES
  logic          found;
  logic [SW-1:0] found_slot;
  logic          have_free;
  logic [SW-1:0] free_slot;
  logic [BW:0]   bidx;          // bitmap scan counter
  logic          got_ib;
  logic [BW-1:0] ib;
  logic [iba_pkg::CNT_W:0] got;
  iba_pkg::rsp_t rsp;
  iba_pkg::rsp_t dec_rsp;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = rsp;

  always_ff @(posedge clk) begin
    if (ptr_we) ptr_mem[ptr_wa] <= ptr_wd;
    if (ptr_re) ptr_rd <= ptr_mem[ptr_ra];
  end

  always_comb begin
    ptr_we = (state == S_SCAN) && (bidx < NUM_BLOCKS) && got_ib &&
             !block_used[bidx[BW-1:0]] && (got < {1'b0, req.block_count});
    ptr_wa = {free_slot, BW'(got)};
    ptr_wd = bidx[BW-1:0];
    ptr_re = (state == S_DEL_RD) || (state == S_TR_RD);
    ptr_ra = (state == S_DEL_RD) ? {found_slot, BW'(got)}
                                 : {found_slot, BW'(req.logical_index)};
  end

  // outcome once the slot search has run through
  always_comb begin
    dec_rsp             = '0;
    dec_rsp.status      = iba_pkg::ST_BAD_INDEX;
    dec_rsp.free_blocks = iba_pkg::FREE_W'(free_count);
    dec_state           = S_OUT;
    unique case (iba_pkg::action_t'(req.action))
      iba_pkg::ACT_INSERT: begin
        if (32'(req.block_count) + 32'd1 > 32'(free_count))
          dec_rsp.status = iba_pkg::ST_TOO_BIG;
        else if (found) begin
          dec_rsp.status      = iba_pkg::ST_EXISTS;
          dec_rsp.index_blk   = 7'(slot_ib[found_slot]);
          dec_rsp.file_blocks = slot_cnt[found_slot];
        end else if (!have_free)
          dec_rsp.status = iba_pkg::ST_NO_SLOT;
        else dec_state = S_SCAN;
      end
      iba_pkg::ACT_DELETE, iba_pkg::ACT_TRANSLATE: begin
        if (!found) dec_rsp.status = iba_pkg::ST_NOT_FOUND;
        else begin
          dec_rsp.index_blk   = 7'(slot_ib[found_slot]);
          dec_rsp.file_blocks = slot_cnt[found_slot];
          if (req.action == iba_pkg::ACT_DELETE) begin
            dec_rsp.status = iba_pkg::ST_OK;
            dec_state      = S_DEL_RD;
          end else if (req.logical_index >= slot_cnt[found_slot] ||
                       32'(req.logical_index) >= NUM_BLOCKS)
            dec_rsp.status = iba_pkg::ST_BAD_INDEX;
          else dec_state = S_TR_RD;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      block_used <= '0;
      slot_valid <= '0;
      free_count <= FW'(NUM_BLOCKS);
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          req        <= in_data;
          sidx       <= '0;
          found      <= 1'b0;
          have_free  <= 1'b0;
          state      <= S_SEARCH;
        end
        S_SEARCH: begin
          if (sidx == (SW+1)'(NUM_FILES)) begin
            rsp    <= dec_rsp;
            bidx   <= '0;
            got    <= '0;
            got_ib <= 1'b0;
            state  <= dec_state;
          end else begin
            if (slot_valid[sidx[SW-1:0]] && !found &&
                slot_key[sidx[SW-1:0]] == req.file_key) begin
              found      <= 1'b1;
              found_slot <= sidx[SW-1:0];
            end
            if (!slot_valid[sidx[SW-1:0]] && !have_free) begin
              have_free <= 1'b1;
              free_slot <= sidx[SW-1:0];
            end
            sidx <= sidx + 1'b1;
          end
        end
        S_SCAN: begin
          if (got_ib && got == {1'b0, req.block_count}) begin
            slot_valid[free_slot] <= 1'b1;
            slot_key[free_slot]   <= req.file_key;
            slot_ib[free_slot]    <= ib;
            slot_cnt[free_slot]   <= req.block_count;
            free_count <= free_count - FW'(req.block_count) - 1'b1;
            rsp.status      <= iba_pkg::ST_OK;
            rsp.index_blk   <= 7'(ib);
            rsp.file_blocks <= req.block_count;
            rsp.free_blocks <= iba_pkg::FREE_W'(free_count - FW'(req.block_count) - 1'b1);
            state <= S_OUT;
          end else if (bidx == (BW+1)'(NUM_BLOCKS)) begin
            // cannot occur while free_count tracks the bitmap
            rsp.status <= iba_pkg::ST_TOO_BIG;
            state <= S_OUT;
          end else begin
            if (!block_used[bidx[BW-1:0]]) begin
              block_used[bidx[BW-1:0]] <= 1'b1;
              if (!got_ib) begin
                got_ib <= 1'b1;
                ib     <= bidx[BW-1:0];
              end else got <= got + 1'b1;
            end
            bidx <= bidx + 1'b1;
          end
        end
        S_DEL_RD: begin
          if (got == {1'b0, slot_cnt[found_slot]}) begin
            slot_valid[found_slot] <= 1'b0;
            if (block_used[slot_ib[found_slot]]) begin
              block_used[slot_ib[found_slot]] <= 1'b0;
              free_count <= free_count + 1'b1;
              rsp.free_blocks <= iba_pkg::FREE_W'(free_count + 1'b1);
            end else rsp.free_blocks <= iba_pkg::FREE_W'(free_count);
            state <= S_OUT;
          end else state <= S_DEL_FREE;
        end
        S_DEL_FREE: begin
          if (block_used[ptr_rd]) begin
            block_used[ptr_rd] <= 1'b0;
            free_count <= free_count + 1'b1;
          end
          got   <= got + 1'b1;
          state <= S_DEL_RD;
        end
        S_TR_RD: state <= S_TR_WAIT;
        S_TR_WAIT: begin
          rsp.status         <= iba_pkg::ST_OK;
          rsp.physical_block <= 7'(ptr_rd);
          state <= S_OUT;
        end
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/indexed_block_allocator.sv]
// ----------------------------------------------------------------------------
// indexed_block_allocator
// Indexed file allocation over a bitmap of disk blocks.
// ----------------------------------------------------------------------------
// One request is executed at a time; a two-entry queue accepts requests
// meanwhile. The back end takes a request in idle, searches all NUM_FILES
// slots, holds the result until it is taken and then returns to idle. An
// insert also scans the bitmap up to the last block it takes and then commits,
// a delete reads each data block pointer from the registered pointer memory
// and frees that block, then frees the index block, and a translate reads its
// pointer in the states S_TR_RD and S_TR_WAIT.
module indexed_block_allocator #(
  parameter int NUM_BLOCKS = 128,
  parameter int NUM_FILES  = 32,
  parameter int KEY_BITS   = 32
) (
  input  logic clk,
  input  logic rst,
  iba_req_if.sink   req,
  iba_rsp_if.source rsp
);
  logic          f_valid, f_ready, q_valid, q_ready;
  iba_pkg::req_t f_data, q_data;

  iba_front #(.KEY_BITS(KEY_BITS)) u_front (
    .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
    .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data));

  iba_queue u_queue (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data));

  iba_back #(.NUM_BLOCKS(NUM_BLOCKS), .NUM_FILES(NUM_FILES)) u_back (
    .clk, .rst,
    .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
    .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data));
endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indexed block allocator: a directed table of
// inserts, deletes, translates and ACT_NONE, then random file traffic, each
// result compared against a behavioral allocator model under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int NBLK = 128;
  localparam int NFIL = 32;
  localparam int RAND_ITEMS = 1400;

  logic clk;
  logic rst;
  iba_req_if req_ch ();
  iba_rsp_if rsp_ch ();

  indexed_block_allocator u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("timeout at %0t", $time);
    $display("CHECKS FAILED");
    $finish;
  end

  // allocator model state
  bit              blk_used [NBLK];
  bit              file_live [NFIL];
  logic [31:0]     file_key_tab [NFIL];
  logic [6:0]      file_index_tab [NFIL];
  logic [6:0]      file_count_tab [NFIL];
  logic [6:0]      file_ptrs [NFIL][NBLK];
  int unsigned     free_total;

  iba_pkg::rsp_t   pending_rsp [$];
  bit              pending_known [$];
  iba_pkg::rsp_t   pending_fixed [$];
  int              errors = 0;
  int              n_ok = 0;
  int              n_err_status = 0;
  int              hold_cycles = 0;
  bit              stim_done = 0;

  function automatic int find_file(logic [31:0] key);
    for (int s = 0; s < NFIL; s++)
      if (file_live[s] && file_key_tab[s] == key) return s;
    return -1;
  endfunction

  function automatic iba_pkg::rsp_t allocate_step(iba_pkg::req_t r);
    iba_pkg::rsp_t o;
    int s, slot, idx;
    int unsigned got;
    o = '0;
    o.status = iba_pkg::ST_BAD_INDEX;
    case (iba_pkg::action_t'(r.action))
      iba_pkg::ACT_INSERT: begin
        s = find_file(r.file_key);
        if (r.block_count + 1 > free_total) begin
          o.status = iba_pkg::ST_TOO_BIG;
        end else if (s >= 0) begin
          o.status = iba_pkg::ST_EXISTS;
          o.index_blk = file_index_tab[s];
          o.file_blocks = file_count_tab[s];
        end else begin
          slot = -1;
          for (int i = 0; i < NFIL; i++)
            if (!file_live[i] && slot < 0) slot = i;
          if (slot < 0) begin
            o.status = iba_pkg::ST_NO_SLOT;
          end else begin
            idx = -1;
            for (int b = 0; b < NBLK; b++)
              if (!blk_used[b] && idx < 0) idx = b;
            blk_used[idx] = 1;
            got = 0;
            for (int b = 0; b < NBLK; b++)
              if (!blk_used[b] && got < r.block_count) begin
                blk_used[b] = 1;
                file_ptrs[slot][got] = b[6:0];
                got++;
              end
            file_live[slot] = 1;
            file_key_tab[slot] = r.file_key;
            file_index_tab[slot] = idx[6:0];
            file_count_tab[slot] = r.block_count;
            free_total -= r.block_count + 1;
            o.status = iba_pkg::ST_OK;
            o.index_blk = idx[6:0];
            o.file_blocks = r.block_count;
          end
        end
      end
      iba_pkg::ACT_DELETE: begin
        s = find_file(r.file_key);
        if (s < 0) begin
          o.status = iba_pkg::ST_NOT_FOUND;
        end else begin
          for (int k = 0; k < file_count_tab[s]; k++)
            if (blk_used[file_ptrs[s][k]]) begin
              blk_used[file_ptrs[s][k]] = 0;
              free_total++;
            end
          if (blk_used[file_index_tab[s]]) begin
            blk_used[file_index_tab[s]] = 0;
            free_total++;
          end
          o.index_blk = file_index_tab[s];
          o.file_blocks = file_count_tab[s];
          file_live[s] = 0;
          o.status = iba_pkg::ST_OK;
        end
      end
      iba_pkg::ACT_TRANSLATE: begin
        s = find_file(r.file_key);
        if (s < 0) begin
          o.status = iba_pkg::ST_NOT_FOUND;
        end else begin
          o.index_blk = file_index_tab[s];
          o.file_blocks = file_count_tab[s];
          if (r.logical_index < file_count_tab[s]) begin
            o.physical_block = file_ptrs[s][r.logical_index];
            o.status = iba_pkg::ST_OK;
          end
        end
      end
      default: ;
    endcase
    o.free_blocks = free_total[7:0];
    return o;
  endfunction

  // directed table; fixed rows carry an expected result, checked against the model
  typedef struct {
    iba_pkg::req_t r;
    bit            fixed;
    iba_pkg::rsp_t e;
  } dir_row_t;

  function automatic iba_pkg::req_t mk_req(iba_pkg::action_t a, logic [31:0] k,
                                           logic [6:0] c, logic [6:0] l);
    iba_pkg::req_t r;
    r.action = a;
    r.file_key = k;
    r.block_count = c;
    r.logical_index = l;
    return r;
  endfunction

  function automatic iba_pkg::rsp_t mk_rsp(iba_pkg::status_t st, int ib, int pb,
                                           int fb, int fr);
    iba_pkg::rsp_t o;
    o.status = st;
    o.index_blk = ib[6:0];
    o.physical_block = pb[6:0];
    o.file_blocks = fb[6:0];
    o.free_blocks = fr[7:0];
    return o;
  endfunction

  dir_row_t dir_rows [$];

  initial begin
    dir_rows.push_back('{mk_req(iba_pkg::ACT_TRANSLATE, 32'h0, 7'd0, 7'd0), 1,
                         mk_rsp(iba_pkg::ST_NOT_FOUND, 0, 0, 0, 128)});
    dir_rows.push_back('{mk_req(iba_pkg::ACT_DELETE, 32'hFFFF_FFFF, 7'h7F, 7'h7F), 1,
                         mk_rsp(iba_pkg::ST_NOT_FOUND, 0, 0, 0, 128)});
    dir_rows.push_back('{mk_req(iba_pkg::ACT_NONE, 32'hFFFF_FFFF, 7'h7F, 7'h7F), 1,
                         mk_rsp(iba_pkg::ST_BAD_INDEX, 0, 0, 0, 128)});
    // 127 + 1 fits exactly
    dir_rows.push_back('{mk_req(iba_pkg::ACT_INSERT, 32'hFFFF_FFFF, 7'd127, 7'd0), 1,
                         mk_rsp(iba_pkg::ST_OK, 0, 0, 127, 0)});
    dir_rows.push_back('{mk_req(iba_pkg::ACT_TRANSLATE, 32'hFFFF_FFFF, 7'd0, 7'd126), 1,
                         mk_rsp(iba_pkg::ST_OK, 0, 127, 127, 0)});
    dir_rows.push_back('{mk_req(iba_pkg::ACT_TRANSLATE, 32'hFFFF_FFFF, 7'd0, 7'd127), 1,
                         mk_rsp(iba_pkg::ST_BAD_INDEX, 0, 0, 127, 0)});
    dir_rows.push_back('{mk_req(iba_pkg::ACT_INSERT, 32'h1, 7'd0, 7'd0), 1,
                         mk_rsp(iba_pkg::ST_TOO_BIG, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_req(iba_pkg::ACT_DELETE, 32'hFFFF_FFFF, 7'd0, 7'd0), 1,
                         mk_rsp(iba_pkg::ST_OK, 0, 0, 127, 128)});
    dir_rows.push_back('{mk_req(iba_pkg::ACT_INSERT, 32'h0, 7'd0, 7'd0), 1,
                         mk_rsp(iba_pkg::ST_OK, 0, 0, 0, 127)});
    dir_rows.push_back('{mk_req(iba_pkg::ACT_TRANSLATE, 32'h0, 7'd0, 7'd0), 1,
                         mk_rsp(iba_pkg::ST_BAD_INDEX, 0, 0, 0, 127)});
    dir_rows.push_back('{mk_req(iba_pkg::ACT_INSERT, 32'h0, 7'd5, 7'd0), 1,
                         mk_rsp(iba_pkg::ST_EXISTS, 0, 0, 0, 127)});
    dir_rows.push_back('{mk_req(iba_pkg::ACT_INSERT, 32'h0, 7'd127, 7'd0), 1,
                         mk_rsp(iba_pkg::ST_TOO_BIG, 0, 0, 0, 127)});
    dir_rows.push_back('{mk_req(iba_pkg::ACT_INSERT, 32'hA5A5_5A5A, 7'd3, 7'd0), 0, '0});
    dir_rows.push_back('{mk_req(iba_pkg::ACT_TRANSLATE, 32'hA5A5_5A5A, 7'd0, 7'd2), 0, '0});
    dir_rows.push_back('{mk_req(iba_pkg::ACT_INSERT, 32'h8000_0000, 7'd2, 7'd0), 0, '0});
    dir_rows.push_back('{mk_req(iba_pkg::ACT_DELETE, 32'hA5A5_5A5A, 7'd0, 7'd0), 0, '0});
    // refill the freed hole below the next file
    dir_rows.push_back('{mk_req(iba_pkg::ACT_INSERT, 32'h5A5A_A5A5, 7'd6, 7'd0), 0, '0});
    dir_rows.push_back('{mk_req(iba_pkg::ACT_TRANSLATE, 32'h5A5A_A5A5, 7'd0, 7'd5), 0, '0});
    for (int i = 0; i < 30; i++)
      dir_rows.push_back('{mk_req(iba_pkg::ACT_INSERT, 32'h100 + i, 7'd0, 7'd0), 0, '0});
    dir_rows.push_back('{mk_req(iba_pkg::ACT_INSERT, 32'h7777, 7'd0, 7'd0), 1,
                         mk_rsp(iba_pkg::ST_NO_SLOT, 0, 0, 0, 88)});
    dir_rows.push_back('{mk_req(iba_pkg::ACT_DELETE, 32'h0, 7'd0, 7'd0), 0, '0});
  end

  // response checker and receiver stalls
  initial begin
    int waitc;
    iba_pkg::rsp_t exp_r;
    bit known;
    iba_pkg::rsp_t fixed_r;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      waitc = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (hold_cycles == 0 && stim_done == 0 && n_ok == 200) begin
        hold_cycles = 1;
        waitc = 2000;
      end
      rsp_ch.ready = 1'b0;
      repeat (waitc) @(negedge clk);
      rsp_ch.ready = 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result %p", $time, rsp_ch.data);
        errors++;
      end else begin
        exp_r = pending_rsp.pop_front();
        known = pending_known.pop_front();
        fixed_r = pending_fixed.pop_front();
        if (known && fixed_r != exp_r) begin
          $display("%0t: table row disagrees: table %p predicted %p",
                   $time, fixed_r, exp_r);
          errors++;
        end
        if (rsp_ch.data.status != exp_r.status ||
            rsp_ch.data.index_blk != exp_r.index_blk ||
            rsp_ch.data.physical_block != exp_r.physical_block ||
            rsp_ch.data.file_blocks != exp_r.file_blocks ||
            rsp_ch.data.free_blocks != exp_r.free_blocks) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_r,
                   rsp_ch.data);
          errors++;
        end
        if (exp_r.status == iba_pkg::ST_OK) n_ok++;
        else n_err_status++;
      end
      @(negedge clk);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_req(iba_pkg::req_t r, bit fixed, iba_pkg::rsp_t e);
    iba_pkg::rsp_t p;
    int gap;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    p = allocate_step(r);
    pending_rsp.push_back(p);
    pending_known.push_back(fixed);
    pending_fixed.push_back(e);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    int s;
    if ($urandom_range(0, 9) < 8) begin
      s = $urandom_range(0, NFIL - 1);
      for (int i = 0; i < NFIL; i++)
        if (file_live[(s + i) % NFIL]) return file_key_tab[(s + i) % NFIL];
    end
    return (($urandom_range(0, 1)) ? $urandom() : 32'($urandom_range(0, 40)));
  endfunction

  initial begin
    iba_pkg::req_t r;
    int  cnt;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    free_total = NBLK;
    for (int i = 0; i < NBLK; i++) blk_used[i] = 0;
    for (int i = 0; i < NFIL; i++) file_live[i] = 0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (dir_rows[i]) send_req(dir_rows[i].r, dir_rows[i].fixed, dir_rows[i].e);
    for (int i = 0; i < RAND_ITEMS; i++) begin
      r.file_key = pick_key();
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: r.action = iba_pkg::ACT_INSERT;
        7, 8, 9, 10, 11: r.action = iba_pkg::ACT_DELETE;
        12: r.action = iba_pkg::ACT_NONE;
        default: r.action = iba_pkg::ACT_TRANSLATE;
      endcase
      if (r.action == iba_pkg::ACT_INSERT && $urandom_range(0, 1))
        r.file_key = $urandom();
      // mostly small files, now and then a large one
      cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
      r.block_count = cnt[6:0];
      r.logical_index = ($urandom_range(0, 7) == 0) ? 7'($urandom()) :
                        7'($urandom_range(0, 9));
      send_req(r, 0, '0);
    end
    req_ch.valid <= 1'b0;
    stim_done = 1;
    fork
      while (pending_rsp.size() != 0) @(posedge clk);
      begin
        repeat (200000) @(posedge clk);
      end
    join_any
    disable fork;
    repeat (300) @(posedge clk);
    $display("covered %0d requests: %0d ok results, %0d error results",
             dir_rows.size() + RAND_ITEMS, n_ok, n_err_status);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d errors, %0d results never arrived", errors, pending_rsp.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
